### rtl/core/ldq_pkg.sv
// ============================================================================
// ldq_pkg
// Shared types and codes for the layered sorted draw queue: the stored entry,
// per-layer control, status codes, layer codes and register indexes.
// ============================================================================
package ldq_pkg;

    // Layers and store limits
    localparam int LAYER_COUNT = 4;
    localparam int STORE_SLOTS = 64;
    localparam int TOTAL_W     = 7;

    // Input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    // Layer codes
    localparam logic [1:0] LAYER_DYNAMIC = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_CULLED   = 3'd1;
    localparam logic [2:0] ST_BAD_LAYER = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DRAINED  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_W = 2'd0;
    localparam logic [1:0] CFG_SCREEN_H = 2'd1;
    localparam logic [1:0] CFG_CAMERA_X = 2'd2;
    localparam logic [1:0] CFG_CAMERA_Y = 2'd3;

    // One stored draw entry
    typedef struct packed {
        logic signed [15:0] key;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [15:0]        tag;
    } t_entry;

    // Per-layer control: insert the broadcast entry, or shift toward the head
    typedef struct packed {
        logic ins;
        logic shift;
    } t_lay_ctl;

endpackage

### rtl/core/ldq_cell.sv
// ============================================================================
// ldq_cell
// One slot of a sorted layer chain. Compares the broadcast key with its own,
// then keeps its entry, takes the new one, or takes its lower neighbor's on
// insert; takes its upper neighbor's entry on a shift toward the head.
// ============================================================================
module ldq_cell (
    input  logic              i_clk,
    input  ldq_pkg::t_lay_ctl i_ctl,
    input  ldq_pkg::t_entry   i_new,
    input  logic              i_occ,
    input  logic              i_prev_occ,
    input  logic              i_prev_ge,
    input  ldq_pkg::t_entry   i_prev_entry,
    input  ldq_pkg::t_entry   i_next_entry,
    output logic              o_ge,
    output ldq_pkg::t_entry   o_entry
);

    ldq_pkg::t_entry r_entry;
    logic            take_new;
    logic            take_prev;

    // Stored key not below the new key: the new entry goes at or before here
    assign o_ge = i_occ && ($signed(i_new.key) <= $signed(r_entry.key));

    // First slot that is free or not below the new key takes the new entry;
    // every slot after it, the first free one included, takes its neighbor's
    assign take_new  = (o_ge || !i_occ) && i_prev_occ && !i_prev_ge;
    assign take_prev = i_prev_ge;

    // Update slot contents
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (take_new) begin
                r_entry <= i_new;
            end else if (take_prev) begin
                r_entry <= i_prev_entry;
            end
        end else if (i_ctl.shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### rtl/core/ldq_layer.sv
// ============================================================================
// ldq_layer
// One draw layer: a row of sorted cells plus its fill count. The head cell
// gives the next entry to drain.
// ============================================================================
module ldq_layer #(
    parameter int DEPTH = 16,
    parameter int FW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ldq_pkg::t_lay_ctl i_ctl,
    input  ldq_pkg::t_entry   i_new,
    output logic [FW-1:0]     o_fill,
    output ldq_pkg::t_entry   o_head
);

    logic [FW-1:0]   r_fill;
    logic            occ   [DEPTH];
    logic            ge    [DEPTH];
    ldq_pkg::t_entry entry [DEPTH];

    // Track the number of stored entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.ins) begin
            r_fill <= r_fill + FW'(1);
        end else if (i_ctl.shift) begin
            r_fill <= r_fill - FW'(1);
        end
    end

    // Build the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign occ[gi] = (r_fill > FW'(gi));
            if (gi == 0) begin : g_head
                ldq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (i_ctl),
                    .i_new        (i_new),
                    .i_occ        (occ[gi]),
                    .i_prev_occ   (1'b1),
                    .i_prev_ge    (1'b0),
                    .i_prev_entry (i_new),
                    .i_next_entry (entry[(gi + 1) % DEPTH]),
                    .o_ge         (ge[gi]),
                    .o_entry      (entry[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_tail
                ldq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (i_ctl),
                    .i_new        (i_new),
                    .i_occ        (occ[gi]),
                    .i_prev_occ   (occ[gi - 1]),
                    .i_prev_ge    (ge[gi - 1]),
                    .i_prev_entry (entry[gi - 1]),
                    .i_next_entry (entry[gi]),
                    .o_ge         (ge[gi]),
                    .o_entry      (entry[gi])
                );
            end else begin : g_mid
                ldq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (i_ctl),
                    .i_new        (i_new),
                    .i_occ        (occ[gi]),
                    .i_prev_occ   (occ[gi - 1]),
                    .i_prev_ge    (ge[gi - 1]),
                    .i_prev_entry (entry[gi - 1]),
                    .i_next_entry (entry[gi + 1]),
                    .o_ge         (ge[gi]),
                    .o_entry      (entry[gi])
                );
            end
        end
    endgenerate

    assign o_fill = r_fill;
    assign o_head = entry[0];

endmodule

### rtl/core/layered_sorted_draw_queue.sv
// ============================================================================
// layered_sorted_draw_queue
// Sorts draw requests into four layers of compare-and-shift cell chains and
// drains them in layer order on a flush.
// ============================================================================
// Insert: camera correction, then cull check with one-pass chain insert, then
//   the registered result; the next item is accepted only once that result is
//   registered, later while the result is stalled.
// Flush: one drained entry per cycle from the head cell while the result is not
//   stalled, with a step past each layer that is empty.
// Reset clears all fill counts and loads screen 640x480, camera at 0.
module layered_sorted_draw_queue #(
    parameter int LAYER_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic [2:0]         i_layer,
    input  logic signed [15:0] i_z_order,
    input  logic               i_hud,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic [14:0]        i_rect_w,
    input  logic [14:0]        i_rect_h,
    input  logic [15:0]        i_element_tag,
    // Result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [1:0]         o_out_layer,
    output logic [15:0]        o_out_tag,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic [14:0]        o_out_w,
    output logic [14:0]        o_out_h,
    output logic               o_last,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int FW = $clog2(LAYER_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CORR  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]   r_state;
    logic [1:0]   n_state;

    // Configuration registers
    logic [14:0]        r_scr_w;
    logic [14:0]        r_scr_h;
    logic signed [15:0] r_cam_x;
    logic signed [15:0] r_cam_y;

    // Captured request
    logic [2:0]         r_layer;
    logic signed [15:0] r_z;
    logic               r_hud;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [14:0]        r_w;
    logic [14:0]        r_h;
    logic [15:0]        r_tag;

    // Drain and occupancy tracking
    logic [1:0]          r_lay;
    logic [ldq_pkg::TOTAL_W-1:0] r_total;

    // Output register
    logic               r_o_valid;
    logic [2:0]         r_o_status;
    logic [1:0]         r_o_layer;
    logic [15:0]        r_o_tag;
    logic signed [15:0] r_o_x;
    logic signed [15:0] r_o_y;
    logic [14:0]        r_o_w;
    logic [14:0]        r_o_h;
    logic               r_o_last;

    // Layer interface
    ldq_pkg::t_lay_ctl  lay_ctl  [ldq_pkg::LAYER_COUNT];
    ldq_pkg::t_entry    lay_head [ldq_pkg::LAYER_COUNT];
    logic [FW-1:0]      lay_fill [ldq_pkg::LAYER_COUNT];
    ldq_pkg::t_entry    new_entry;

    logic               accept;
    logic               out_free;
    logic [16:0]        diff_x;
    logic [16:0]        diff_y;
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [16:0] sum_x;
    logic signed [16:0] sum_y;
    logic               cull;
    logic               full;
    logic [2:0]         ins_status;
    logic               exec_go;
    logic               drain_empty;
    logic               drain_emit;
    logic               drain_skip;

    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= 15'd640;
            r_scr_h <= 15'd480;
            r_cam_x <= '0;
            r_cam_y <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ldq_pkg::CFG_SCREEN_W: r_scr_w <= i_cfg_data[14:0];
                ldq_pkg::CFG_SCREEN_H: r_scr_h <= i_cfg_data[14:0];
                ldq_pkg::CFG_CAMERA_X: r_cam_x <= i_cfg_data;
                ldq_pkg::CFG_CAMERA_Y: r_cam_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturating camera subtraction
    assign diff_x = {r_x[15], r_x} - {r_cam_x[15], r_cam_x};
    assign diff_y = {r_y[15], r_y} - {r_cam_y[15], r_cam_y};
    assign corr_x = (diff_x[16] != diff_x[15]) ?
                    (diff_x[16] ? 16'sh8000 : 16'sh7fff) : diff_x[15:0];
    assign corr_y = (diff_y[16] != diff_y[15]) ?
                    (diff_y[16] ? 16'sh8000 : 16'sh7fff) : diff_y[15:0];

    // Cull test on corrected coordinates
    assign sum_x = {r_x[15], r_x} + $signed({2'b00, r_w});
    assign sum_y = {r_y[15], r_y} + $signed({2'b00, r_h});
    assign cull  = (sum_x <= 17'sd0) || (sum_y <= 17'sd0)
                || (r_x > $signed({1'b0, r_scr_w}))
                || (r_y > $signed({1'b0, r_scr_h}));

    assign full = (lay_fill[r_layer[1:0]] == FW'(LAYER_DEPTH))
               || (r_total >= ldq_pkg::TOTAL_W'(ldq_pkg::STORE_SLOTS));

    // Pick the insert status by priority
    always_comb begin
        priority if (cull) begin
            ins_status = ldq_pkg::ST_CULLED;
        end else if (r_layer[2]) begin
            ins_status = ldq_pkg::ST_BAD_LAYER;
        end else if (full) begin
            ins_status = ldq_pkg::ST_FULL;
        end else begin
            ins_status = ldq_pkg::ST_ACCEPTED;
        end
    end

    assign exec_go     = (r_state == S_EXEC) && out_free;
    assign drain_empty = (r_state == S_DRAIN) && out_free && (r_total == '0);
    assign drain_emit  = (r_state == S_DRAIN) && out_free && (r_total != '0)
                      && (lay_fill[r_lay] != '0);
    assign drain_skip  = (r_state == S_DRAIN) && (r_total != '0)
                      && (lay_fill[r_lay] == '0);

    // Entry broadcast to the layer chains
    always_comb begin
        new_entry.key = (r_layer[1:0] == ldq_pkg::LAYER_DYNAMIC) ? r_y : r_z;
        new_entry.x   = r_x;
        new_entry.y   = r_y;
        new_entry.w   = r_w;
        new_entry.h   = r_h;
        new_entry.tag = r_tag;
    end

    // Layer chains
    genvar gl;
    generate
        for (gl = 0; gl < ldq_pkg::LAYER_COUNT; gl++) begin : g_layer
            assign lay_ctl[gl].ins = exec_go && (ins_status == ldq_pkg::ST_ACCEPTED)
                                  && (r_layer[1:0] == 2'(gl));
            assign lay_ctl[gl].shift = drain_emit && (r_lay == 2'(gl));

            ldq_layer #(
                .DEPTH (LAYER_DEPTH),
                .FW    (FW)
            ) u_layer (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lay_ctl[gl]),
                .i_new   (new_entry),
                .o_fill  (lay_fill[gl]),
                .o_head  (lay_head[gl])
            );
        end
    endgenerate

    // Sequence one item at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_action == ldq_pkg::ACT_FLUSH) ? S_DRAIN : S_CORR;
                end
            end
            S_CORR: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (drain_empty || (drain_emit && r_total == ldq_pkg::TOTAL_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lay   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_lay <= '0;
            end else if (drain_skip) begin
                r_lay <= r_lay + 2'd1;
            end
            if (exec_go && ins_status == ldq_pkg::ST_ACCEPTED) begin
                r_total <= r_total + ldq_pkg::TOTAL_W'(1);
            end else if (drain_emit) begin
                r_total <= r_total - ldq_pkg::TOTAL_W'(1);
            end
        end
    end

    // Capture the request and apply the camera correction unless it is a HUD request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_layer <= i_layer;
            r_z     <= i_z_order;
            r_hud   <= i_hud;
            r_x     <= i_rect_x;
            r_y     <= i_rect_y;
            r_w     <= i_rect_w;
            r_h     <= i_rect_h;
            r_tag   <= i_element_tag;
        end else if (r_state == S_CORR && !r_hud) begin
            r_x <= corr_x;
            r_y <= corr_y;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (exec_go || drain_empty || drain_emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (drain_emit) begin
            r_o_status <= ldq_pkg::ST_DRAINED;
            r_o_layer  <= r_lay;
            r_o_tag    <= lay_head[r_lay].tag;
            r_o_x      <= lay_head[r_lay].x;
            r_o_y      <= lay_head[r_lay].y;
            r_o_w      <= lay_head[r_lay].w;
            r_o_h      <= lay_head[r_lay].h;
            r_o_last   <= (r_total == ldq_pkg::TOTAL_W'(1));
        end else if (exec_go || drain_empty) begin
            r_o_status <= drain_empty ? ldq_pkg::ST_EMPTY : ins_status;
            r_o_layer  <= '0;
            r_o_tag    <= '0;
            r_o_x      <= '0;
            r_o_y      <= '0;
            r_o_w      <= '0;
            r_o_h      <= '0;
            r_o_last   <= 1'b1;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_out_layer = r_o_layer;
    assign o_out_tag   = r_o_tag;
    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_out_w     = r_o_w;
    assign o_out_h     = r_o_h;
    assign o_last      = r_o_last;

endmodule

### bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the layered sorted draw queue. A scripted opening
// covers the cull edges, bad and culled layers, equal keys and empty flushes.
// Random phases under several screen and camera views follow. They push
// layers past capacity and drain full stores. A behavioral sorter predicts
// every result item, and each arriving item is checked against it in order.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAYER_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int SCRIPT_LEN  = 20;
    // Layer choice for random requests
    localparam int ANY_LAYER   = -1;
    localparam int VALID_LAYER = -2;

    typedef struct packed {
        logic               action;
        logic [2:0]         layer;
        logic signed [15:0] z;
        logic               hud;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [15:0]        tag;
    } t_draw_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  layer;
        logic [15:0] tag;
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic        last;
    } t_draw_result;

    typedef struct {
        logic       action;
        int         layer;
        int         z;
        logic       hud;
        int         x;
        int         y;
        int         w;
        int         h;
        int         tag;
        logic       known;
        logic [2:0] status;
    } t_script_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_action;
    logic [2:0]         i_layer;
    logic signed [15:0] i_z_order;
    logic               i_hud;
    logic signed [15:0] i_rect_x;
    logic signed [15:0] i_rect_y;
    logic [14:0]        i_rect_w;
    logic [14:0]        i_rect_h;
    logic [15:0]        i_element_tag;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic [1:0]         o_out_layer;
    logic [15:0]        o_out_tag;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic [14:0]        o_out_w;
    logic [14:0]        o_out_h;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    // Predicted view registers and sorted layers
    int              view_w;
    int              view_h;
    int              cam_x;
    int              cam_y;
    ldq_pkg::t_entry sorted_layer [ldq_pkg::LAYER_COUNT][LAYER_DEPTH];
    int              layer_fill [ldq_pkg::LAYER_COUNT];
    t_draw_result    due_results [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int hold_mode   = 0;
    int hold_left   = 0;
    int hold_tick   = 0;

    // Opening script; status is typed in only where it is plain to see
    t_script_row script [SCRIPT_LEN] = '{
        '{ldq_pkg::ACT_FLUSH,  0, 0, 1'b0, 0, 0, 0, 0, 'h0000, 1'b1, ldq_pkg::ST_EMPTY},
        '{ldq_pkg::ACT_INSERT, 0, 5, 1'b0, 10, 10, 8, 8, 'h0001, 1'b1, ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 0, 5, 1'b0, 20, 20, 8, 8, 'h0002, 1'b0, ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 0, -32768, 1'b0, 30, 30, 8, 8, 'h0003, 1'b0,
          ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 0, 32767, 1'b0, 40, 40, 8, 8, 'h0004, 1'b0,
          ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 1, 0, 1'b0, 50, 300, 4, 4, 'h0010, 1'b0, ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 1, 9, 1'b0, 60, 300, 4, 4, 'h0011, 1'b0, ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 1, 0, 1'b0, 70, -5, 4, 10, 'h0012, 1'b0, ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 2, 0, 1'b1, -100, -100, 32767, 32767, 'hFFFF, 1'b1,
          ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 3, 0, 1'b1, 640, 480, 0, 1, 'h8000, 1'b1,
          ldq_pkg::ST_ACCEPTED},
        '{ldq_pkg::ACT_INSERT, 4, 0, 1'b0, 10, 10, 8, 8, 'h0020, 1'b1, ldq_pkg::ST_BAD_LAYER},
        '{ldq_pkg::ACT_INSERT, 7, 0, 1'b0, 641, 10, 8, 8, 'h0021, 1'b1, ldq_pkg::ST_CULLED},
        '{ldq_pkg::ACT_INSERT, 2, 0, 1'b0, -10, 10, 10, 8, 'h0022, 1'b1, ldq_pkg::ST_CULLED},
        '{ldq_pkg::ACT_INSERT, 2, 0, 1'b0, 10, -10, 8, 10, 'h0023, 1'b1, ldq_pkg::ST_CULLED},
        '{ldq_pkg::ACT_INSERT, 2, 0, 1'b0, 10, 481, 8, 8, 'h0024, 1'b1, ldq_pkg::ST_CULLED},
        '{ldq_pkg::ACT_INSERT, 2, 0, 1'b1, -32768, -32768, 0, 0, 'h0025, 1'b1,
          ldq_pkg::ST_CULLED},
        '{ldq_pkg::ACT_INSERT, 2, 0, 1'b0, 32767, 32767, 32767, 32767, 'h0026, 1'b1,
          ldq_pkg::ST_CULLED},
        '{ldq_pkg::ACT_FLUSH,  0, 0, 1'b0, 0, 0, 0, 0, 'h0000, 1'b0, ldq_pkg::ST_EMPTY},
        '{ldq_pkg::ACT_FLUSH,  5, -1, 1'b1, -1, -1, 32767, 32767, 'hFFFF, 1'b1,
          ldq_pkg::ST_EMPTY},
        '{ldq_pkg::ACT_INSERT, 3, 1, 1'b0, 0, 0, 1, 1, 'h7FFF, 1'b1, ldq_pkg::ST_ACCEPTED}
    };

    layered_sorted_draw_queue #(
        .LAYER_DEPTH(LAYER_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_layer       (i_layer),
        .i_z_order     (i_z_order),
        .i_hud         (i_hud),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_w      (i_rect_w),
        .i_rect_h      (i_rect_h),
        .i_element_tag (i_element_tag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_out_layer   (o_out_layer),
        .o_out_tag     (o_out_tag),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_w       (o_out_w),
        .o_out_h       (o_out_h),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a camera-corrected coordinate to 16 bit signed
    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Work out the result items of one accepted request and update the layers
    function automatic void sort_request(t_draw_req r);
        t_draw_result    res;
        ldq_pkg::t_entry e;
        int              sx, sy, total, l, pos, k;
        res      = '0;
        res.last = 1'b1;
        total    = 0;
        for (l = 0; l < ldq_pkg::LAYER_COUNT; l++) total += layer_fill[l];
        if (r.action == ldq_pkg::ACT_FLUSH) begin
            if (total == 0) begin
                res.status = ldq_pkg::ST_EMPTY;
                due_results.push_back(res);
            end else begin
                // Drain layer by layer, head first
                k = 0;
                for (l = 0; l < ldq_pkg::LAYER_COUNT; l++) begin
                    for (pos = 0; pos < layer_fill[l]; pos++) begin
                        k++;
                        res.status = ldq_pkg::ST_DRAINED;
                        res.layer  = 2'(l);
                        res.tag    = sorted_layer[l][pos].tag;
                        res.x      = sorted_layer[l][pos].x;
                        res.y      = sorted_layer[l][pos].y;
                        res.w      = sorted_layer[l][pos].w;
                        res.h      = sorted_layer[l][pos].h;
                        res.last   = (k == total);
                        due_results.push_back(res);
                    end
                    layer_fill[l] = 0;
                end
            end
        end else begin
            sx = $signed(r.x);
            sy = $signed(r.y);
            if (!r.hud) begin
                sx = clamp16(sx - cam_x);
                sy = clamp16(sy - cam_y);
            end
            if (sx + int'(r.w) <= 0 || sy + int'(r.h) <= 0 || sx > view_w || sy > view_h) begin
                res.status = ldq_pkg::ST_CULLED;
            end else if (int'(r.layer) >= ldq_pkg::LAYER_COUNT) begin
                res.status = ldq_pkg::ST_BAD_LAYER;
            end else begin
                l = int'(r.layer);
                if (layer_fill[l] >= LAYER_DEPTH || total >= ldq_pkg::STORE_SLOTS) begin
                    res.status = ldq_pkg::ST_FULL;
                end else begin
                    // Insert ahead of the first entry with an equal or greater key
                    e.key = (r.layer[1:0] == ldq_pkg::LAYER_DYNAMIC) ? 16'(sy) : r.z;
                    e.x   = 16'(sx);
                    e.y   = 16'(sy);
                    e.w   = r.w;
                    e.h   = r.h;
                    e.tag = r.tag;
                    pos   = 0;
                    while (pos < layer_fill[l] && e.key > sorted_layer[l][pos].key) pos++;
                    for (k = layer_fill[l]; k > pos; k--) sorted_layer[l][k] = sorted_layer[l][k-1];
                    sorted_layer[l][pos] = e;
                    layer_fill[l]++;
                    res.status = ldq_pkg::ST_ACCEPTED;
                end
            end
            due_results.push_back(res);
        end
    endfunction

    // Build a random request; most land near the visible screen
    function automatic t_draw_req random_request(int flush_pct, int lay_sel);
        t_draw_req r;
        int        base_x, base_y;
        r.action = ($urandom_range(0, 99) < flush_pct) ? ldq_pkg::ACT_FLUSH
                                                        : ldq_pkg::ACT_INSERT;
        if (lay_sel >= 0) begin
            r.layer = 3'(lay_sel);
        end else if (lay_sel == ANY_LAYER && $urandom_range(0, 9) == 0) begin
            r.layer = 3'($urandom_range(4, 7));
        end else begin
            r.layer = 3'($urandom_range(0, 3));
        end
        r.hud = 1'($urandom_range(0, 1));
        r.tag = 16'($urandom);
        r.z   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15) - 8) : 16'($urandom);
        r.w   = ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 64));
        r.h   = ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 64));
        if ($urandom_range(0, 4) == 0) begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
        end else begin
            base_x = r.hud ? 0 : cam_x;
            base_y = r.hud ? 0 : cam_y;
            r.x = 16'(base_x + int'($urandom_range(0, view_w + 40)) - 20);
            r.y = 16'(base_y + int'($urandom_range(0, view_h + 40)) - 20);
        end
        return r;
    endfunction

    // Present one request in bursts with random gaps, predict on accept
    task automatic send_request(input t_draw_req r, input logic known, input logic [2:0] status);
        t_draw_result typed;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        i_valid       <= 1'b1;
        i_action      <= r.action;
        i_layer       <= r.layer;
        i_z_order     <= r.z;
        i_hud         <= r.hud;
        i_rect_x      <= r.x;
        i_rect_y      <= r.y;
        i_rect_w      <= r.w;
        i_rect_h      <= r.h;
        i_element_tag <= r.tag;
        do @(posedge i_clk); while (o_stall);
        sort_request(r);
        // Replace the prediction with the typed-in status where one is given
        if (known) begin
            typed        = '0;
            typed.status = status;
            typed.last   = 1'b1;
            void'(due_results.pop_back());
            due_results.push_back(typed);
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    // Hold requests until every expected item is back, then let the block settle
    task automatic drain_and_pause();
        i_valid   <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Write all four view registers, only while the block is idle
    task automatic set_view(input logic [15:0] sw, sh, cx, cy);
        logic [15:0] value [4];
        logic [1:0]  index [4];
        int          n;
        value = '{sw, sh, cx, cy};
        index = '{ldq_pkg::CFG_SCREEN_W, ldq_pkg::CFG_SCREEN_H,
                  ldq_pkg::CFG_CAMERA_X, ldq_pkg::CFG_CAMERA_Y};
        for (n = 0; n < 4; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= index[n];
            i_cfg_data  <= value[n];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (index[n])
                ldq_pkg::CFG_SCREEN_W: view_w = int'(value[n][14:0]);
                ldq_pkg::CFG_SCREEN_H: view_h = int'(value[n][14:0]);
                ldq_pkg::CFG_CAMERA_X: cam_x = $signed(value[n]);
                default:               cam_y = $signed(value[n]);
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stall the result side in changing patterns: none, light, periodic, heavy
    always @(negedge i_clk) begin
        if (hold_left == 0) begin
            hold_mode = $urandom_range(0, 3);
            hold_left = $urandom_range(16, 96);
        end
        hold_left--;
        hold_tick++;
        case (hold_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: i_stall <= ((hold_tick % 5) >= 3);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Check each accepted result item against the oldest expectation
    always @(posedge i_clk) begin
        t_draw_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result item: status %0d layer %0d tag %h last %0b",
                             o_status, o_out_layer, o_out_tag, o_last);
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status || o_out_layer !== want.layer ||
                    o_out_tag !== want.tag || o_out_x !== want.x || o_out_y !== want.y ||
                    o_out_w !== want.w || o_out_h !== want.h || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: expected st %0d lay %0d tag %h x %0d y %0d w %0d h %0d last %0b",
                                 want.status, want.layer, want.tag, $signed(want.x),
                                 $signed(want.y), want.w, want.h, want.last);
                        $display("          actual   st %0d lay %0d tag %h x %0d y %0d w %0d h %0d last %0b",
                                 o_status, o_out_layer, o_out_tag, o_out_x, o_out_y,
                                 o_out_w, o_out_h, o_last);
                    end
                end
            end
        end
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** layered_sorted_draw_queue: FAILED **");
            $finish;
        end
    end

    initial begin
        t_draw_req req;
        int        i;
        int        n;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ldq_pkg::ACT_INSERT;
        i_layer       = '0;
        i_z_order     = '0;
        i_hud         = 1'b0;
        i_rect_x      = '0;
        i_rect_y      = '0;
        i_rect_w      = '0;
        i_rect_h      = '0;
        i_element_tag = '0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = ldq_pkg::CFG_SCREEN_W;
        i_cfg_data    = '0;
        view_w        = 640;
        view_h        = 480;
        cam_x         = 0;
        cam_y         = 0;
        for (i = 0; i < ldq_pkg::LAYER_COUNT; i++) layer_fill[i] = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the opening script under the reset view
        for (i = 0; i < SCRIPT_LEN; i++) begin
            req.action = script[i].action;
            req.layer  = 3'(script[i].layer);
            req.z      = 16'(script[i].z);
            req.hud    = script[i].hud;
            req.x      = 16'(script[i].x);
            req.y      = 16'(script[i].y);
            req.w      = 15'(script[i].w);
            req.h      = 15'(script[i].h);
            req.tag    = 16'(script[i].tag);
            send_request(req, script[i].known, script[i].status);
        end
        drain_and_pause();

        // Reset view: mixed traffic, then overrun the dynamic layer and drain
        for (n = 0; n < 15; n++)
            send_request(random_request(10, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        for (n = 0; n < 18; n++)
            send_request(random_request(0, int'(ldq_pkg::LAYER_DYNAMIC)), 1'b0,
                         ldq_pkg::ST_ACCEPTED);
        send_request(random_request(100, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        drain_and_pause();

        // Widest screen, camera at the negative extreme: fill the whole store
        set_view(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        for (n = 0; n < 80; n++)
            send_request(random_request(0, VALID_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        send_request(random_request(100, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        drain_and_pause();

        // Empty screen, camera at the positive extreme
        set_view(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
        for (n = 0; n < 10; n++)
            send_request(random_request(20, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        send_request(random_request(100, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        drain_and_pause();

        // Random view
        set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        for (n = 0; n < 10; n++)
            send_request(random_request(15, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        send_request(random_request(100, ANY_LAYER), 1'b0, ldq_pkg::ST_ACCEPTED);
        drain_and_pause();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** layered_sorted_draw_queue: PASSED **");
        end else begin
            $display("** layered_sorted_draw_queue: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/ldq_pkg.sv
rtl/core/ldq_cell.sv
rtl/core/ldq_layer.sv
rtl/core/layered_sorted_draw_queue.sv
bench/testbench.sv
